FILE: src/pstg_pkg.sv
// Package for the polyphonic square tone generator: widths, codes, link types
// and the elaboration-time note period table. Depends on nothing.
`default_nettype none

package pstg_pkg;

    localparam int CHANNELS_DEF    = 16;
    localparam int NOTES_DEF       = 128;
    localparam int SAMPLE_RATE_DEF = 44100;

    localparam int CHAN_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int TOTAL_W = 11;
    localparam int PHASE_W = 14;
    localparam int SUM_W   = 16;
    localparam int ACT_W   = 2;
    localparam int IN_W    = 24;

    localparam int FRAC_BITS = 36;
    localparam longint unsigned RATIO_NUM = 64'd105946;
    localparam longint unsigned RATIO_DEN = 64'd100000;
    localparam longint unsigned BASE_HZ   = 64'd440;
    localparam int BASE_NOTE = 69;
    localparam int GAIN      = 10;
    localparam int PHASE_MAX = 16383;

    typedef enum logic [ACT_W-1:0] {
        ACT_NOTE_OFF = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_NONE     = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NOTE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               en;
        logic [NOTE_W-1:0]  note;
        logic [TOTAL_W-1:0] delta;
    } upd_t;

    typedef struct packed {
        logic             tok;
        logic [SUM_W-1:0] sum;
    } link_t;

    function automatic logic [63:0] ratio_pow(input int k);
        logic [63:0] x;
        x = 64'd1 << FRAC_BITS;
        for (int i = 0; i < k; i++) begin
            x = (x * RATIO_NUM + RATIO_DEN / 64'd2) / RATIO_DEN;
        end
        return x;
    endfunction

    function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [PHASE_W-1:0] period_of(input int rate, input int j);
        int          d;
        logic [63:0] p;
        logic [63:0] r;
        d = j - BASE_NOTE;
        if (d == 0) begin
            p = long_div(64'(rate), BASE_HZ);
        end
        else if (d < 0) begin
            r = ratio_pow(-d);
            p = long_div(64'(rate) * r, BASE_HZ << FRAC_BITS);
        end
        else begin
            r = ratio_pow(d);
            p = long_div(64'(rate) << FRAC_BITS, BASE_HZ * r);
        end
        if (p < 64'd1) begin
            p = 64'd1;
        end
        if (p > 64'(PHASE_MAX)) begin
            p = 64'(PHASE_MAX);
        end
        return p[PHASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/polyphonic_square_tone_generator.sv
// Polyphonic square tone generator: a velocity per channel and note is kept in
// a RAM, and per-note totals and phases in a row of cells that a token sweeps
// once per sample tick. Each transfer takes one item. A note event occupies
// the block for a RAM read, then for a RAM write and cell update; a tick
// occupies it while the token walks the cell row one cell per clock and while
// the previous sample still waits in the output register for m_tready, and
// yields one sample in the output register, which holds while the next item is
// taken. Action code 3 and events with a channel or note out of range are taken
// and dropped. After reset a clearing pass zeroes every entry of the velocity
// RAM, with no input taken. Depends on pstg_pkg, pstg_ram and pstg_cell.
`default_nettype none

module polyphonic_square_tone_generator #(
    parameter int CHANNELS    = pstg_pkg::CHANNELS_DEF,
    parameter int NOTES       = pstg_pkg::NOTES_DEF,
    parameter int SAMPLE_RATE = pstg_pkg::SAMPLE_RATE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pstg_pkg::IN_W-1:0] s_tdata,  // channel[3:0], note[10:4], velocity[17:11]
    input  wire logic [pstg_pkg::ACT_W-1:0] s_tuser, // action[1:0]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [pstg_pkg::SUM_W-1:0]     m_tdata   // sample[15:0]
);

    localparam int VEL_DEPTH = CHANNELS * NOTES;
    localparam int VEL_AW    = (VEL_DEPTH > 1) ? $clog2(VEL_DEPTH) : 1;
    localparam logic [VEL_AW-1:0] CLR_LAST = VEL_AW'(VEL_DEPTH - 1);

    pstg_pkg::state_t state_reg;
    pstg_pkg::state_t state_next;

    logic [VEL_AW-1:0]              clr_addr_reg;
    logic [VEL_AW-1:0]              clr_addr_next;
    logic [VEL_AW-1:0]              addr_reg;
    logic [VEL_AW-1:0]              addr_next;
    logic [pstg_pkg::NOTE_W-1:0]    note_reg;
    logic [pstg_pkg::NOTE_W-1:0]    note_next;
    logic [pstg_pkg::VEL_W-1:0]     nv_reg;
    logic [pstg_pkg::VEL_W-1:0]     nv_next;
    logic [pstg_pkg::SUM_W-1:0]     res_reg;
    logic [pstg_pkg::SUM_W-1:0]     res_next;
    logic [pstg_pkg::SUM_W-1:0]     out_reg;
    logic [pstg_pkg::SUM_W-1:0]     out_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    pstg_pkg::link_t                head_reg;
    pstg_pkg::link_t                head_next;

    pstg_pkg::act_t                 act;
    logic [pstg_pkg::CHAN_W-1:0]    in_chan;
    logic [pstg_pkg::NOTE_W-1:0]    in_note;
    logic [pstg_pkg::VEL_W-1:0]     in_vel;
    logic                           in_range;
    logic [VEL_AW-1:0]              in_addr;
    logic                           take;

    logic                           ram_we;
    logic [VEL_AW-1:0]              ram_waddr;
    logic [pstg_pkg::VEL_W-1:0]     ram_wdata;
    logic [pstg_pkg::VEL_W-1:0]     ram_rdata;

    pstg_pkg::upd_t                 upd;
    pstg_pkg::link_t                links [NOTES+1];
    logic [NOTES:0]                 tok_vec;

    assign act      = pstg_pkg::act_t'(s_tuser);
    assign in_chan  = s_tdata[3:0];
    assign in_note  = s_tdata[10:4];
    assign in_vel   = s_tdata[17:11];
    assign in_range = (32'(in_chan) < CHANNELS) && (32'(in_note) < NOTES);
    assign in_addr  = VEL_AW'(32'(in_chan) * NOTES + 32'(in_note));
    assign s_tready = (state_reg == pstg_pkg::ST_IDLE);
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        addr_next      = addr_reg;
        note_next      = note_reg;
        nv_next        = nv_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        head_next      = '0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = nv_reg;
        upd            = '0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pstg_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = pstg_pkg::ST_IDLE;
                end
            end
            pstg_pkg::ST_IDLE: begin
                if (take) begin
                    addr_next = in_addr;
                    note_next = in_note;
                    nv_next   = (act == pstg_pkg::ACT_NOTE_ON) ? in_vel : '0;
                    case (act)
                        pstg_pkg::ACT_NOTE_OFF, pstg_pkg::ACT_NOTE_ON: begin
                            if (in_range) begin
                                state_next = pstg_pkg::ST_NOTE;
                            end
                        end
                        pstg_pkg::ACT_TICK: begin
                            head_next.tok = 1'b1;
                            head_next.sum = '0;
                            state_next    = pstg_pkg::ST_SWEEP;
                        end
                        default: begin
                            state_next = pstg_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pstg_pkg::ST_NOTE: begin
                ram_we     = 1'b1;
                upd.en     = 1'b1;
                upd.note   = note_reg;
                upd.delta  = pstg_pkg::TOTAL_W'(nv_reg) - pstg_pkg::TOTAL_W'(ram_rdata);
                state_next = pstg_pkg::ST_IDLE;
            end
            pstg_pkg::ST_SWEEP: begin
                if (links[NOTES].tok) begin
                    res_next   = links[NOTES].sum;
                    state_next = pstg_pkg::ST_EMIT;
                end
            end
            pstg_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_next       = pstg_pkg::SUM_W'(32'(res_reg) * pstg_pkg::GAIN);
                    out_valid_next = 1'b1;
                    state_next     = pstg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pstg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= pstg_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
        end
        else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk) begin
        addr_reg <= addr_next;
        note_reg <= note_next;
        nv_reg   <= nv_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    pstg_ram #(
        .WIDTH (pstg_pkg::VEL_W),
        .DEPTH (VEL_DEPTH)
    ) u_vel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    assign links[0]   = head_reg;
    assign tok_vec[0] = links[0].tok;

    for (genvar g = 0; g < NOTES; g++) begin : g_cell
        pstg_cell #(
            .INDEX       (g),
            .SAMPLE_RATE (SAMPLE_RATE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .upd      (upd),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
        assign tok_vec[g+1] = links[g+1].tok;
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one sweep token in the cell row");

    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (|tok_vec) |-> (state_reg == pstg_pkg::ST_SWEEP))
        else $error("sweep token outside of a sweep");

    a_tick_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (act == pstg_pkg::ACT_TICK)) |=> (state_reg == pstg_pkg::ST_SWEEP))
        else $error("tick transfer did not start a sweep");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == pstg_pkg::ST_CLEAR) || (state_reg == pstg_pkg::ST_NOTE)))
        else $error("velocity RAM written outside clear or note update");

    a_update_after_note: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> $past(take))
        else $error("cell update without a preceding note transfer");

endmodule

`default_nettype wire

FILE: src/pstg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module pstg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/pstg_cell.sv
// One note cell: velocity total and phase counter of one note, adding its
// share to the sample sum as the sweep token passes. Depends on pstg_pkg.
`default_nettype none

module pstg_cell #(
    parameter int INDEX       = 0,
    parameter int SAMPLE_RATE = pstg_pkg::SAMPLE_RATE_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pstg_pkg::upd_t  upd,
    input  wire pstg_pkg::link_t link_in,
    output pstg_pkg::link_t      link_out
);

    localparam logic [pstg_pkg::PHASE_W-1:0] PERIOD =
        pstg_pkg::period_of(SAMPLE_RATE, INDEX);
    localparam logic [pstg_pkg::PHASE_W-1:0] HALF = PERIOD >> 1;

    logic [pstg_pkg::TOTAL_W-1:0] total_reg;
    logic [pstg_pkg::TOTAL_W-1:0] total_next;
    logic [pstg_pkg::PHASE_W-1:0] phase_reg;
    logic [pstg_pkg::PHASE_W-1:0] phase_next;
    logic [pstg_pkg::PHASE_W-1:0] phase_inc;
    pstg_pkg::link_t              link_reg;
    pstg_pkg::link_t              link_next;

    always_comb begin
        total_next = total_reg;
        if (upd.en && (upd.note == pstg_pkg::NOTE_W'(INDEX))) begin
            total_next = total_reg + upd.delta;
        end

        phase_inc  = phase_reg + 1'b1;
        phase_next = phase_reg;
        link_next  = '0;
        if (link_in.tok) begin
            phase_next = (phase_inc >= PERIOD) ? '0 : phase_inc;
            link_next.tok = 1'b1;
            link_next.sum = link_in.sum;
            if (phase_reg >= HALF) begin
                link_next.sum = link_in.sum + pstg_pkg::SUM_W'(total_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= '0;
            phase_reg <= '0;
            link_reg  <= '0;
        end
        else begin
            total_reg <= total_next;
            phase_reg <= phase_next;
            link_reg  <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

FILE: dv/polyphonic_square_tone_generator_tb.sv
// Testbench for polyphonic_square_tone_generator: streams note and tick items,
// predicts every sample and checks each output transfer against it.
// Depends on pstg_pkg and the generator RTL.
`default_nettype none

class tone_checker;
    localparam int CHANNELS = pstg_pkg::CHANNELS_DEF;
    localparam int NOTES    = pstg_pkg::NOTES_DEF;

    logic [pstg_pkg::VEL_W-1:0]   chan_vel [CHANNELS*NOTES];
    logic [pstg_pkg::TOTAL_W-1:0] note_sum [NOTES];
    int unsigned                  phase [NOTES];
    int unsigned                  period [NOTES];
    logic [pstg_pkg::SUM_W-1:0]   pending_samples [$];
    int                           errors;
    int                           samples_seen;

    function new();
        foreach (chan_vel[i])
        begin
            chan_vel[i] = '0;
        end
        for (int j = 0; j < NOTES; j++)
        begin
            note_sum[j] = '0;
            phase[j]    = 0;
            period[j]   = period_for(j);
        end
        errors       = 0;
        samples_seen = 0;
    endfunction

    // 440 Hz at note 69, a ratio of 1.05946 per semitone, in fixed point
    function int unsigned period_for(int j);
        longint unsigned rate;
        longint unsigned r;
        longint unsigned p;
        int              d;
        rate = longint'(pstg_pkg::SAMPLE_RATE_DEF);
        d    = j - pstg_pkg::BASE_NOTE;
        r    = longint'(1) << pstg_pkg::FRAC_BITS;
        repeat ((d < 0) ? -d : d)
        begin
            r = (r * pstg_pkg::RATIO_NUM + pstg_pkg::RATIO_DEN / 2) / pstg_pkg::RATIO_DEN;
        end
        if (d == 0)
        begin
            p = rate / pstg_pkg::BASE_HZ;
        end
        else if (d < 0)
        begin
            p = (rate * r) / (pstg_pkg::BASE_HZ << pstg_pkg::FRAC_BITS);
        end
        else
        begin
            p = (rate << pstg_pkg::FRAC_BITS) / (pstg_pkg::BASE_HZ * r);
        end
        if (p < 1)
        begin
            p = 1;
        end
        if (p > pstg_pkg::PHASE_MAX)
        begin
            p = pstg_pkg::PHASE_MAX;
        end
        return int'(p);
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    function void note_input(pstg_pkg::act_t act, logic [3:0] ch, logic [6:0] nt,
                             logic [6:0] vel);
        int          idx;
        logic [6:0]  nv;
        int unsigned acc;
        case (act)
            pstg_pkg::ACT_NOTE_OFF, pstg_pkg::ACT_NOTE_ON:
            begin
                nv  = (act == pstg_pkg::ACT_NOTE_ON) ? vel : 7'd0;
                idx = int'(ch) * NOTES + int'(nt);
                note_sum[nt]  = note_sum[nt] - chan_vel[idx] + nv;
                chan_vel[idx] = nv;
            end
            pstg_pkg::ACT_TICK:
            begin
                acc = 0;
                for (int j = 0; j < NOTES; j++)
                begin
                    if (phase[j] >= period[j] / 2)
                    begin
                        acc += note_sum[j];
                    end
                    phase[j]++;
                    if (phase[j] >= period[j])
                    begin
                        phase[j] = 0;
                    end
                end
                acc = acc * pstg_pkg::GAIN;
                pending_samples.push_back(acc[pstg_pkg::SUM_W-1:0]);
            end
            default:
            begin
            end
        endcase
    endfunction

    task check_sample(logic [pstg_pkg::SUM_W-1:0] got);
        logic [pstg_pkg::SUM_W-1:0] want;
        samples_seen++;
        if (pending_samples.size() == 0)
        begin
            report($sformatf("sample %0d arrived with none pending", $signed(got)));
        end
        else
        begin
            want = pending_samples.pop_front();
            if (got !== want)
            begin
                report($sformatf("sample #%0d: got %0d, want %0d", samples_seen,
                                 $signed(got), $signed(want)));
            end
        end
    endtask
endclass

module polyphonic_square_tone_generator_tb;
    import pstg_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 410;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [ACT_W-1:0]  s_tuser = ACT_NONE;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [SUM_W-1:0]  m_tdata;

    tone_checker sb;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int quiet_cycles = 0;
    int note_events = 0;
    int ticks_sent = 0;
    int ignored_items = 0;

    polyphonic_square_tone_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_sample(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input act_t act, input logic [3:0] ch, input logic [6:0] nt,
                             input logic [6:0] vel);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, vel, nt, ch};
        s_tuser  <= act;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_input(act, ch, nt, vel);
        case (act)
            ACT_TICK:
            begin
                ticks_sent++;
            end
            ACT_NONE:
            begin
                ignored_items++;
            end
            default:
            begin
                note_events++;
            end
        endcase
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        act_t       act;
        int         pick;
        logic [6:0] nt;
        logic [6:0] vel;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                act = ACT_TICK;
            end
            else if (pick < 80)
            begin
                act = ACT_NOTE_ON;
            end
            else if (pick < 95)
            begin
                act = ACT_NOTE_OFF;
            end
            else
            begin
                act = ACT_NONE;
            end
            // favor notes fast enough to swing within the run
            nt  = ($urandom_range(1) == 1) ? 7'($urandom_range(127)) : 7'($urandom_range(127, 45));
            vel = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127));
            send_item(act, 4'($urandom_range(15)), nt, vel);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_samples.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 22;
        snk_idle_pct = 77;

        send_item(ACT_NOTE_ON,  4'd0,  7'd0,   7'd127);
        send_item(ACT_NOTE_ON,  4'd15, 7'd127, 7'd127);
        send_item(ACT_NOTE_ON,  4'd15, 7'd127, 7'd1);
        send_item(ACT_NOTE_ON,  4'd7,  7'd127, 7'd85);
        send_item(ACT_NOTE_ON,  4'd8,  7'd126, 7'd42);
        send_item(ACT_NOTE_ON,  4'd3,  7'd69,  7'd100);
        send_item(ACT_NOTE_ON,  4'd5,  7'd69,  7'd0);
        send_item(ACT_NOTE_OFF, 4'd0,  7'd0,   7'd127);
        send_item(ACT_NONE,     4'd15, 7'd127, 7'd127);
        repeat (4)
        begin
            send_item(ACT_TICK, 4'd0, 7'd0, 7'd0);
        end
        send_item(ACT_NOTE_OFF, 4'd15, 7'd127, 7'd0);
        for (int c = 9; c <= 14; c++)
        begin
            send_item(ACT_NOTE_ON, 4'(c), 7'd127, 7'd127);
        end
        repeat (6)
        begin
            send_item(ACT_TICK, 4'd15, 7'd127, 7'd127);
        end

        send_random(RANDOM_PER_PHASE);
        hold_until_drained();

        src_idle_pct = 77;
        snk_idle_pct = 22;
        send_random(RANDOM_PER_PHASE);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(RANDOM_PER_PHASE);
        s_tvalid <= 1'b0;

        while (sb.pending_samples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (NOTES_DEF + 8) @(negedge clk);
        if (sb.pending_samples.size() != 0)
        begin
            sb.report($sformatf("%0d samples never arrived", sb.pending_samples.size()));
        end

        $display("Covered %0d note events, %0d ticks and %0d unused-code items", note_events,
                 ticks_sent, ignored_items);
        $display("Checked %0d samples under three stall patterns; %0d mismatches",
                 sb.samples_seen, sb.errors);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
src/pstg_pkg.sv
src/pstg_ram.sv
src/pstg_cell.sv
src/polyphonic_square_tone_generator.sv
dv/polyphonic_square_tone_generator_tb.sv
